[src/spg_pkg.sv]
`default_nettype none

package spg_pkg;

  localparam int unsigned MAX_ELEMS_DEF = 8;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = 1;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                   kind;
    logic signed [VALUE_W-1:0]   value;
    logic                        last;
  } cmd_t;

endpackage

`default_nettype wire

[src/spg_if.sv]
`default_nettype none

interface spg_in_if import spg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [VALUE_W-1:0] value;
  logic                      last_in;

  modport source (output valid, op, value, last_in, input ready);
  modport sink   (input valid, op, value, last_in, output ready);
endinterface

interface spg_out_if import spg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] elem_value;
  logic        [POS_W-1:0]   elem_pos;
  logic                      last_of_run;
  logic                      none_left;

  modport source (output valid, elem_value, elem_pos, last_of_run, none_left, input ready);
  modport sink   (input valid, elem_value, elem_pos, last_of_run, none_left, output ready);
endinterface

`default_nettype wire

[src/spg_front.sv]
`default_nettype none

module spg_front import spg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spg_in_if.sink    in_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  wire logic cmd_ready_i
);

  logic fv_q, fv_d;
  cmd_t fcmd_q, fcmd_d;

  assign in_i.ready = !fv_q || cmd_ready_i;

  always_comb begin
    fv_d   = fv_q && !cmd_ready_i;
    fcmd_d = fcmd_q;
    if (in_i.valid && in_i.ready) begin
      fv_d         = 1'b1;
      fcmd_d.kind  = cmd_kind_e'(in_i.op);
      fcmd_d.value = (cmd_kind_e'(in_i.op) == CMD_LOAD) ? in_i.value : '0;
      fcmd_d.last  = in_i.last_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fcmd_q <= fcmd_d;
  end

  assign cmd_valid_o = fv_q;
  assign cmd_o       = fcmd_q;

endmodule

`default_nettype wire

[src/spg_queue.sv]
`default_nettype none

module spg_queue import spg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  input  wire cmd_t push_cmd_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output cmd_t      pop_cmd_o,
  input  wire logic pop_ready_i
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

[src/spg_back.sv]
`default_nettype none

module spg_back import spg_pkg::*; #(
  parameter int unsigned MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_ready_o,
  spg_out_if.source out_o
);

  localparam int unsigned IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMS + 1);

  typedef enum logic [12:0] {
    S_IDLE     = 13'h0001,
    S_NONE     = 13'h0002,
    S_INIT     = 13'h0004,
    S_ADV_RD   = 13'h0008,
    S_ADV_CHK  = 13'h0010,
    S_SW_RA    = 13'h0020,
    S_SW_RB    = 13'h0040,
    S_SW_WA    = 13'h0080,
    S_SW_WB    = 13'h0100,
    S_ADV_NEXT = 13'h0200,
    S_FILL     = 13'h0400,
    S_EMIT_RD  = 13'h0800,
    S_EMIT_OUT = 13'h1000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] size_q, size_d;
  logic complete_q, complete_d, started_q, started_d, finished_q, finished_d;
  logic [IW-1:0] k_q, k_d, m_q, m_d, c_q, c_d, swx_q, swx_d, swy_q, swy_d;
  logic sw_second_q, sw_second_d;
  logic signed [VALUE_W-1:0] tmp_q, tmp_d;

  logic signed [VALUE_W-1:0] elem_mem [MAX_ELEMS];
  logic signed [VALUE_W-1:0] elem_rd_q, elem_wdata;
  logic [IW-1:0] elem_waddr, elem_raddr;
  logic elem_we;

  logic [IW-1:0] cidx_mem [MAX_ELEMS];
  logic [IW-1:0] cidx_rd_q, cidx_wdata, cidx_waddr, cidx_raddr;
  logic cidx_we;

  logic out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic out_last_q, out_last_d, out_none_q, out_none_d;

  logic out_free;
  logic [CW-1:0] last_idx, nj, size_eff;
  logic m_at_last;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_o.ready;
  assign last_idx    = size_q - CW'(1);
  assign nj          = CW'(c_q) + CW'(1);
  assign size_eff    = complete_q ? '0 : size_q;
  assign m_at_last   = (CW'(m_q) == last_idx);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    complete_d  = complete_q;
    started_d   = started_q;
    finished_d  = finished_q;
    k_d         = k_q;
    m_d         = m_q;
    c_d         = c_q;
    swx_d       = swx_q;
    swy_d       = swy_q;
    sw_second_d = sw_second_q;
    tmp_d       = tmp_q;
    elem_we     = 1'b0;
    elem_waddr  = swx_q;
    elem_wdata  = elem_rd_q;
    elem_raddr  = m_q;
    cidx_we     = 1'b0;
    cidx_waddr  = m_q;
    cidx_wdata  = m_q;
    cidx_raddr  = k_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_value_d = out_value_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_none_d  = out_none_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_LOAD) begin
            if (complete_q) begin
              started_d  = 1'b0;
              finished_d = 1'b0;
            end
            size_d = size_eff;
            if (size_eff < CW'(MAX_ELEMS)) begin
              elem_we    = 1'b1;
              elem_waddr = IW'(size_eff);
              elem_wdata = cmd_i.value;
              size_d     = size_eff + CW'(1);
            end
            complete_d = cmd_i.last;
          end else if (!complete_q || finished_q || size_q == '0) begin
            state_d = S_NONE;
          end else if (!started_q) begin
            started_d = 1'b1;
            m_d       = '0;
            state_d   = S_INIT;
          end else if (size_q <= CW'(1)) begin
            finished_d = 1'b1;
            state_d    = S_NONE;
          end else begin
            k_d     = IW'(last_idx - CW'(1));
            state_d = S_ADV_RD;
          end
        end
      end
      S_NONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_pos_d   = '0;
          out_last_d  = 1'b0;
          out_none_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_INIT, S_FILL: begin
        cidx_we = 1'b1;
        if (m_at_last) begin
          m_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          m_d = m_q + IW'(1);
        end
      end
      S_ADV_RD: begin
        state_d = S_ADV_CHK;
      end
      S_ADV_CHK: begin
        c_d         = cidx_rd_q;
        swx_d       = k_q;
        swy_d       = cidx_rd_q;
        sw_second_d = 1'b0;
        state_d     = S_SW_RA;
      end
      S_SW_RA: begin
        elem_raddr = swx_q;
        state_d    = S_SW_RB;
      end
      S_SW_RB: begin
        elem_raddr = swy_q;
        tmp_d      = elem_rd_q;
        state_d    = S_SW_WA;
      end
      S_SW_WA: begin
        elem_we    = 1'b1;
        elem_waddr = swx_q;
        elem_wdata = elem_rd_q;
        state_d    = S_SW_WB;
      end
      S_SW_WB: begin
        elem_we    = 1'b1;
        elem_waddr = swy_q;
        elem_wdata = tmp_q;
        if (sw_second_q) begin
          m_d     = k_q + IW'(1);
          state_d = S_FILL;
        end else begin
          state_d = S_ADV_NEXT;
        end
      end
      S_ADV_NEXT: begin
        if (nj < size_q) begin
          cidx_we     = 1'b1;
          cidx_waddr  = k_q;
          cidx_wdata  = IW'(nj);
          swy_d       = IW'(nj);
          sw_second_d = 1'b1;
          state_d     = S_SW_RA;
        end else if (k_q == '0) begin
          finished_d = 1'b1;
          state_d    = S_NONE;
        end else begin
          k_d     = k_q - IW'(1);
          state_d = S_ADV_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = elem_rd_q;
          out_pos_d   = POS_W'(m_q);
          out_last_d  = m_at_last;
          out_none_d  = 1'b0;
          if (m_at_last) begin
            state_d = S_IDLE;
          end else begin
            m_d     = m_q + IW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= '0;
      complete_q  <= 1'b0;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      k_q         <= '0;
      m_q         <= '0;
      c_q         <= '0;
      swx_q       <= '0;
      swy_q       <= '0;
      sw_second_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      complete_q  <= complete_d;
      started_q   <= started_d;
      finished_q  <= finished_d;
      k_q         <= k_d;
      m_q         <= m_d;
      c_q         <= c_d;
      swx_q       <= swx_d;
      swy_q       <= swy_d;
      sw_second_q <= sw_second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q       <= tmp_d;
    out_value_q <= out_value_d;
    out_pos_q   <= out_pos_d;
    out_last_q  <= out_last_d;
    out_none_q  <= out_none_d;
  end

  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    elem_rd_q <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cidx_we) begin
      cidx_mem[cidx_waddr] <= cidx_wdata;
    end
    cidx_rd_q <= cidx_mem[cidx_raddr];
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.elem_value  = out_value_q;
  assign out_o.elem_pos    = out_pos_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.none_left   = out_none_q;

endmodule

`default_nettype wire

[src/swap_permutation_generator_top.sv]
// A load item reaches the sequencer after the front register and the queue and is taken
// there while it is idle. A next item emits a none-left result or the elements from the
// element memory, each read in S_EMIT_RD and sent in S_EMIT_OUT, which waits while the
// output is not free; undoing one level of the choice stack runs S_ADV_RD, S_ADV_CHK,
// a swap (S_SW_RA to S_SW_WB) and S_ADV_NEXT; an advance adds a second swap and refills
// levels in S_FILL, and the first request of a set fills the choice table in S_INIT.
// Reset clears all control state and empties the queue; the element memory is not cleared.
`default_nettype none

module swap_permutation_generator_top import spg_pkg::*; #(
  parameter int unsigned MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spg_in_if.sink    in_i,
  spg_out_if.source out_o
);

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  spg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (f_ready)
  );

  spg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_cmd_i   (f_cmd),
    .push_ready_o (f_ready),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd),
    .pop_ready_i  (q_ready)
  );

  spg_back #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (q_ready),
    .out_o       (out_o)
  );

  a_none_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.none_left) |->
      (out_o.elem_value == '0 && out_o.elem_pos == '0 && !out_o.last_of_run))
    else $error("none-left result carries nonzero fields");

  a_next_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready && q_cmd.kind == CMD_NEXT) |=> !q_ready)
    else $error("sequencer took a next item without starting work");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.none_left && !out_o.last_of_run) |-> !q_ready)
    else $error("sequencer idle in the middle of a permutation run");

endmodule

`default_nettype wire
